// ----- src/trg_pkg.sv -----
// ----------------------------------------------------------------------------
// trg_pkg
// Shared types, codes and fixed-point constants of the trapezoidal ramp
// generator.
// ----------------------------------------------------------------------------
package trg_pkg;

  localparam int POS_FRAC_BITS   = 8;
  localparam int SPEED_FRAC_BITS = 4;
  localparam int ARRIVE_WINDOW   = 2;

  localparam int DVD_W = 51;
  localparam int MOD_W = 27;
  localparam int REM_W = 24;
  localparam int CNT_W = 6;

  localparam logic [2:0] OP_TICK           = 3'd0;
  localparam logic [2:0] OP_GOTO           = 3'd1;
  localparam logic [2:0] OP_SET_POS        = 3'd2;
  localparam logic [2:0] OP_SET_POS_MOVING = 3'd3;
  localparam logic [2:0] OP_REL_MOVE       = 3'd4;

  localparam logic [1:0] REG_MAX_SPEED   = 2'd0;
  localparam logic [1:0] REG_MAX_ACCEL   = 2'd1;
  localparam logic [1:0] REG_MAX_DECEL   = 2'd2;
  localparam logic [1:0] REG_WRAP_LENGTH = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TGT,
    ST_TMOD,
    ST_TFIX,
    ST_DIST,
    ST_DMOD,
    ST_DFIX,
    ST_CHK,
    ST_MUL,
    ST_LD,
    ST_SDIV,
    ST_DEC,
    ST_POS,
    ST_SPAN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [23:0] position;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] current_position;
    logic signed [31:0] current_speed;
    logic               arrived;
  } out_item_t;

endpackage

// ----- src/trapezoidal_ramp_generator.sv -----
// ----------------------------------------------------------------------------
// trapezoidal_ramp_generator
// One-axis trapezoidal velocity profile with optional circular wrap.
// ----------------------------------------------------------------------------
// One item is in work at a time; the input stalls until it is finished, while
// a finished beat may still wait at the output. On a circular axis, goto and
// set operations and ticks each add a wrap modulo. A tick that snaps to the
// target skips the stop distance division; one that accelerates while max
// decel is below max accel checks the stop distance again. The one shared
// restoring divider retires one quotient bit per cycle for the wrap modulo
// and for both stop distance divisions.
module trapezoidal_ramp_generator (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  trg_pkg::in_item_t    in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output trg_pkg::out_item_t   out_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [22:0]          cfg_wdata
);
  import trg_pkg::*;

  state_t state_r, state_nxt;

  logic [14:0] max_speed_r, max_accel_r, max_decel_r;
  logic [22:0] wrap_len_r;

  logic [2:0]         op_r;
  logic signed [26:0] arg_r, arg_nxt;
  logic signed [23:0] tgt_r, tgt_nxt;
  logic signed [31:0] fine_r, fine_nxt;
  logic signed [31:0] vel_r, vel_nxt;
  logic signed [24:0] d_r, d_nxt;
  logic hit_r, hit_nxt;
  logic pos_r, pos_nxt;
  logic phase_r, phase_nxt;
  logic neg_r, neg_nxt;
  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [22:0]      dvsr_r, dvsr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0] prod_r, prod_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r, out_data_nxt;

  logic               len_nz;
  logic [22:0]        half;
  logic [22+POS_FRAC_BITS:0] span;
  logic signed [23:0] fine_int;
  logic signed [24:0] raw_d;
  logic signed [26:0] dist_arg;
  logic signed [26:0] tgt_arg;
  logic [MOD_W-1:0]   dist_mag, arg_mag;
  logic [REM_W-1:0]   rem_sh, rem_sub;
  logic               rem_ge;
  logic [22:0]        mod_r0, mod_res;
  logic signed [23:0] tgt_mod;
  logic [31:0]        abs_sp;
  logic               hit_cond;
  logic [26:0]        ma;
  logic [23:0]        mb;
  logic signed [25:0] e;
  logic               e_gt, e_lt;
  logic signed [33:0] v34, lim34, acc34, dec34, sp2, t34;
  logic [31:0]        vel_dec;
  logic               need_mul2;
  logic signed [32:0] fine33, span33;
  logic               div_last;

  assign len_nz   = |wrap_len_r;
  assign half     = {1'b0, wrap_len_r[22:1]};
  assign span     = {wrap_len_r, {POS_FRAC_BITS{1'b0}}};
  assign fine_int = 24'(fine_r >>> POS_FRAC_BITS);
  assign raw_d    = 25'(tgt_r) - 25'(fine_int);
  assign dist_arg = 27'(raw_d) + $signed({4'b0, wrap_len_r}) + $signed({4'b0, half});
  assign tgt_arg  = (in_data.operation == OP_REL_MOVE) ?
                    27'(tgt_r) + 27'(in_data.position) : 27'(in_data.position);
  assign dist_mag = dist_arg[26] ? MOD_W'(-dist_arg) : MOD_W'(dist_arg);
  assign arg_mag  = arg_r[26] ? MOD_W'(-arg_r) : MOD_W'(arg_r);

  assign rem_sh   = {rem_r[REM_W-2:0], dvd_r[DVD_W-1]};
  assign rem_ge   = rem_sh >= {1'b0, dvsr_r};
  assign rem_sub  = rem_sh - {1'b0, dvsr_r};
  assign div_last = cnt_r == CNT_W'(1);

  assign mod_r0  = rem_r[22:0];
  assign mod_res = (neg_r && (mod_r0 != 23'd0)) ? wrap_len_r - mod_r0 : mod_r0;
  assign tgt_mod = $signed({1'b0, mod_res});

  assign abs_sp   = vel_r[31] ? 32'(-vel_r) : 32'(vel_r);
  assign hit_cond = (d_r > -25'(ARRIVE_WINDOW)) && (d_r < 25'(ARRIVE_WINDOW)) &&
                    ((abs_sp >> 1) <= 32'(max_decel_r));

  always_comb begin
    if (!phase_r) begin
      ma = 27'(abs_sp >> (SPEED_FRAC_BITS + 1));
      mb = 24'(abs_sp >> POS_FRAC_BITS);
    end else if (pos_r) begin
      ma = 27'(vel_r >>> (SPEED_FRAC_BITS + 1));
      mb = 24'(vel_r >>> POS_FRAC_BITS);
    end else begin
      ma = 27'(-(vel_r >>> (SPEED_FRAC_BITS + 1)));
      mb = 24'(-(vel_r >>> POS_FRAC_BITS));
    end
  end

  assign e     = pos_r ? 26'(d_r) : -26'(d_r);
  assign e_gt  = !e[25] && (DVD_W'(e[24:0]) > dvd_r);
  assign e_lt  = e[25] || (DVD_W'(e[24:0]) < dvd_r);
  assign v34   = 34'(vel_r);
  assign lim34 = $signed(34'({max_speed_r, {SPEED_FRAC_BITS{1'b0}}}));
  assign acc34 = $signed(34'(max_accel_r));
  assign dec34 = $signed(34'(max_decel_r));

  always_comb begin
    need_mul2 = 1'b0;
    sp2       = v34;
    t34       = v34;
    if (!phase_r) begin
      if (pos_r) begin
        if (e_gt) begin
          if (v34 < lim34) begin
            sp2 = v34 + acc34;
            if (max_decel_r < max_accel_r) begin
              need_mul2 = 1'b1;
              t34 = sp2;
            end else begin
              t34 = (sp2 > lim34) ? lim34 : sp2;
            end
          end else if (v34 > lim34) begin
            t34 = v34 - dec34;
          end
        end else begin
          t34 = v34 - dec34 - acc34;
        end
      end else begin
        if (e_gt) begin
          if (v34 > -lim34) begin
            sp2 = v34 - acc34;
            if (max_decel_r < max_accel_r) begin
              need_mul2 = 1'b1;
              t34 = sp2;
            end else begin
              t34 = (sp2 < -lim34) ? -lim34 : sp2;
            end
          end else if (v34 < -lim34) begin
            t34 = v34 + dec34;
          end
        end else begin
          t34 = v34 + dec34 + acc34;
        end
      end
    end else begin
      if (pos_r) begin
        sp2 = e_lt ? v34 - (acc34 - dec34) : v34;
        t34 = (sp2 > lim34) ? lim34 : sp2;
      end else begin
        sp2 = e_lt ? v34 + (acc34 - dec34) : v34;
        t34 = (sp2 < -lim34) ? -lim34 : sp2;
      end
    end
    vel_dec = t34[31:0];
  end

  assign fine33 = 33'(fine_r);
  assign span33 = $signed({2'b0, span});

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.operation == OP_TICK) begin
            state_nxt = ST_DIST;
          end else if (in_data.operation inside {OP_GOTO, OP_SET_POS, OP_SET_POS_MOVING,
                                                 OP_REL_MOVE}) begin
            state_nxt = ST_TGT;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_TGT:  state_nxt = len_nz ? ST_TMOD : ST_OUT;
      ST_TMOD: state_nxt = div_last ? ST_TFIX : ST_TMOD;
      ST_TFIX: state_nxt = ST_OUT;
      ST_DIST: state_nxt = len_nz ? ST_DMOD : ST_CHK;
      ST_DMOD: state_nxt = div_last ? ST_DFIX : ST_DMOD;
      ST_DFIX: state_nxt = ST_CHK;
      ST_CHK:  state_nxt = hit_cond ? ST_SPAN : ST_MUL;
      ST_MUL:  state_nxt = ST_LD;
      ST_LD:   state_nxt = ST_SDIV;
      ST_SDIV: state_nxt = div_last ? ST_DEC : ST_SDIV;
      ST_DEC:  state_nxt = need_mul2 ? ST_MUL : ST_POS;
      ST_POS:  state_nxt = ST_SPAN;
      ST_SPAN: state_nxt = ST_OUT;
      ST_OUT:  state_nxt = (!out_valid_r || !out_stall) ? ST_IDLE : ST_OUT;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    arg_nxt       = arg_r;
    tgt_nxt       = tgt_r;
    fine_nxt      = fine_r;
    vel_nxt       = vel_r;
    d_nxt         = d_r;
    hit_nxt       = hit_r;
    pos_nxt       = pos_r;
    phase_nxt     = phase_r;
    neg_nxt       = neg_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    dvsr_nxt      = dvsr_r;
    cnt_nxt       = cnt_r;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_IDLE: begin
        hit_nxt = 1'b0;
        arg_nxt = tgt_arg;
      end
      ST_TGT: begin
        if (len_nz) begin
          dvd_nxt  = {arg_mag, {(DVD_W - MOD_W){1'b0}}};
          rem_nxt  = '0;
          dvsr_nxt = wrap_len_r;
          cnt_nxt  = CNT_W'(MOD_W);
          neg_nxt  = arg_r[26];
        end else begin
          tgt_nxt = arg_r[23:0];
          if (op_r == OP_SET_POS || op_r == OP_SET_POS_MOVING) begin
            fine_nxt = 32'(arg_r[23:0]) <<< POS_FRAC_BITS;
          end
          if (op_r == OP_SET_POS) begin
            vel_nxt = '0;
          end
        end
      end
      ST_TMOD, ST_DMOD, ST_SDIV: begin
        rem_nxt = rem_ge ? rem_sub : rem_sh;
        dvd_nxt = {dvd_r[DVD_W-2:0], rem_ge};
        cnt_nxt = cnt_r - CNT_W'(1);
      end
      ST_TFIX: begin
        tgt_nxt = tgt_mod;
        if (op_r == OP_SET_POS || op_r == OP_SET_POS_MOVING) begin
          fine_nxt = 32'(tgt_mod) <<< POS_FRAC_BITS;
        end
        if (op_r == OP_SET_POS) begin
          vel_nxt = '0;
        end
      end
      ST_DIST: begin
        if (len_nz) begin
          dvd_nxt  = {dist_mag, {(DVD_W - MOD_W){1'b0}}};
          rem_nxt  = '0;
          dvsr_nxt = wrap_len_r;
          cnt_nxt  = CNT_W'(MOD_W);
          neg_nxt  = dist_arg[26];
        end else begin
          d_nxt = raw_d;
        end
      end
      ST_DFIX: begin
        d_nxt = $signed({2'b0, mod_res}) - $signed({2'b0, half});
      end
      ST_CHK: begin
        if (hit_cond) begin
          fine_nxt = 32'(tgt_r) <<< POS_FRAC_BITS;
          vel_nxt  = '0;
          hit_nxt  = 1'b1;
        end else begin
          pos_nxt   = !vel_r[31];
          phase_nxt = 1'b0;
        end
      end
      ST_MUL: begin
        prod_nxt = {{(DVD_W - 27){1'b0}}, ma} * {{(DVD_W - 24){1'b0}}, mb};
      end
      ST_LD: begin
        dvd_nxt  = prod_r;
        rem_nxt  = '0;
        dvsr_nxt = (max_decel_r == 15'd0) ? 23'd1 : 23'(max_decel_r);
        cnt_nxt  = CNT_W'(DVD_W);
      end
      ST_DEC: begin
        vel_nxt = vel_dec;
        if (need_mul2) begin
          phase_nxt = 1'b1;
        end
      end
      ST_POS: begin
        fine_nxt = fine_r + 32'(vel_r >>> SPEED_FRAC_BITS);
      end
      ST_SPAN: begin
        if (fine_r[31]) begin
          fine_nxt = 32'(fine33 + span33);
        end else if (fine33 >= span33) begin
          fine_nxt = 32'(fine33 - span33);
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt                 = 1'b1;
          out_data_nxt.current_position = fine_int;
          out_data_nxt.current_speed    = vel_r;
          out_data_nxt.arrived          = hit_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      max_speed_r <= '0;
      max_accel_r <= '0;
      max_decel_r <= 15'd1;
      wrap_len_r  <= '0;
      tgt_r       <= '0;
      fine_r      <= '0;
      vel_r       <= '0;
      hit_r       <= 1'b0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tgt_r       <= tgt_nxt;
      fine_r      <= fine_nxt;
      vel_r       <= vel_nxt;
      hit_r       <= hit_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_SPEED:   max_speed_r <= cfg_wdata[14:0];
          REG_MAX_ACCEL:   max_accel_r <= cfg_wdata[14:0];
          REG_MAX_DECEL:   max_decel_r <= cfg_wdata[14:0];
          REG_WRAP_LENGTH: wrap_len_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      op_r <= in_data.operation;
    end
    arg_r      <= arg_nxt;
    d_r        <= d_nxt;
    pos_r      <= pos_nxt;
    neg_r      <= neg_nxt;
    dvd_r      <= dvd_nxt;
    rem_r      <= rem_nxt;
    dvsr_r     <= dvsr_nxt;
    cnt_r      <= cnt_nxt;
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = state_r != ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> state_r != ST_IDLE)
    else $error("accepted beat did not start work");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result beat raised outside the output step");

  a_arrived_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.arrived) |-> out_data_r.current_speed == 32'sd0)
    else $error("arrived beat with nonzero speed");

  a_recheck_accel: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DEC && phase_r) |-> max_accel_r > max_decel_r)
    else $error("second stop check without accel above decel");

endmodule
